[hw/rtl/baaq_pkg.sv]
// Shared constants, types and lookup functions for the block-average ASCII quantizer.
package baaq_pkg;

    // Image limits and brightness scale
    localparam int MAX_IMAGE_WIDTH  = 4096;
    localparam int MAX_IMAGE_HEIGHT = 4096;
    localparam int FULL_BRIGHTNESS  = 765;

    // Field and datapath widths
    localparam int PIX_W     = 8;
    localparam int CHAR_W    = 7;
    localparam int DIM_W     = 13;
    localparam int GIDX_W    = $clog2(MAX_IMAGE_WIDTH);
    localparam int LEVEL_W   = 10;
    localparam int COUNT_W   = 2 * DIM_W;
    localparam int SUM_W     = 34;
    localparam int THR_W     = 37;
    localparam int SUM10_W   = 38;
    localparam int NUM_THR   = 7;
    localparam int CFG_IDX_W = 2;

    // Queue depths
    localparam int ITEM_Q_DEPTH = 4;
    localparam int IQ_PTR_W     = $clog2(ITEM_Q_DEPTH);
    localparam int OUT_Q_DEPTH  = 4;
    localparam int OQ_PTR_W     = $clog2(OUT_Q_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0] RST_TEXT_COLUMNS = 13'd80;
    localparam logic [DIM_W-1:0] RST_TEXT_ROWS    = 13'd40;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

    typedef logic [THR_W-1:0] thr_t;

    // Live frame geometry and the group setup derived from it
    typedef struct packed {
        logic                    ready;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
        logic [DIM_W-1:0]        gw;
        logic [DIM_W-1:0]        gh;
        thr_t [NUM_THR-1:0]      thr;
    } dims_t;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [GIDX_W-1:0]  gidx;
        logic               acc;
        logic               first_col;
        logic               first_row;
        logic               last_col;
        logic               emit;
        logic               nl;
        logic               fs;
    } item_t;

    typedef struct packed {
        logic has_item;
        logic has_space;
    } q_stat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_of_run;
    } oq_entry_t;

    // Brightness thresholds in tenths
    function automatic logic [3:0] tenth(input logic [2:0] i);
        logic [3:0] t;
        case (i)
            3'd0:    t = 4'd1;
            3'd1:    t = 4'd2;
            3'd2:    t = 4'd3;
            3'd3:    t = 4'd4;
            3'd4:    t = 4'd5;
            3'd5:    t = 4'd6;
            default: t = 4'd8;
        endcase
        return t;
    endfunction

    // Character ramp, darkest first
    function automatic logic [CHAR_W-1:0] glyph_code(input logic [2:0] i);
        logic [CHAR_W-1:0] c;
        case (i)
            3'd0:    c = 7'd32;   // space
            3'd1:    c = 7'd58;   // colon
            3'd2:    c = 7'd42;   // asterisk
            3'd3:    c = 7'd111;  // o
            3'd4:    c = 7'd38;   // ampersand
            3'd5:    c = 7'd42;   // asterisk
            3'd6:    c = 7'd64;   // at sign
            default: c = 7'd35;   // hash
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/baaq_if.sv]
// Valid/ready channel interfaces for pixels in and characters out.
interface baaq_pix_if;
    import baaq_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface baaq_chr_if;
    import baaq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_run;

    modport source (output valid, char_code, last_of_run, input ready);
    modport sink   (input valid, char_code, last_of_run, output ready);
endinterface

[hw/rtl/block_average_ascii_quantizer_unit.sv]
// Top level of the block-average ASCII quantizer.
//
// pixels: RGB pixels in raster order, valid/ready; a transfer moves one pixel.
// chars:  ASCII characters, valid/ready; last_of_run marks the final character
//         caused by one pixel (a group glyph, then a newline after a band's last group).
// cfg_*:  register write port (image_width, image_height, text_columns, text_rows).
//         Write only while the block is idle.
//
// Throughput: one pixel per cycle while the receiver keeps up. A pixel that closes
// the last group of a band yields two characters, which leave one after the other
// through the one output port. A character passes from its pixel through the item
// queue, stage 1, stage 2 and the output buffer. After reset, and after every
// register write, pixels.ready stays low while the serial divider and multipliers
// work out group size and brightness thresholds. The group sum memory has no reset;
// it is written by the first row of each band before it is read.
// When the receiver stalls, a four-entry output buffer and a four-entry queue
// between the front and back sections fill, then pixels.ready drops.
module block_average_ascii_quantizer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    baaq_pix_if.sink                       pixels,
    baaq_chr_if.source                     chars,
    input  logic                           cfg_write,
    input  logic [baaq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [baaq_pkg::DIM_W-1:0]     cfg_data
);
    import baaq_pkg::*;

    dims_t   dims;
    q_stat_t q_stat;
    item_t   q_item, q_head;
    logic    q_push, q_pop;

    baaq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims)
    );

    baaq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .dims   (dims),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (q_item)
    );

    baaq_item_q u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_item),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    baaq_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .dims   (dims),
        .chars  (chars)
    );

    // A register write restarts setup, so no pixel is taken right after it
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !pixels.ready)
        else $error("pixel taken during group setup");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.has_item)
        else $error("item queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_stat.has_space)
        else $error("item queue pushed while full");

    // A newline always closes the run of its pixel
    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.char_code == CHAR_NEWLINE) |-> chars.last_of_run)
        else $error("newline not marked as last of run");

endmodule

[hw/rtl/baaq_cfg.sv]
// Configuration registers and the serial setup of group size and brightness thresholds.
module baaq_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [baaq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [baaq_pkg::DIM_W-1:0]        cfg_data,
    output baaq_pkg::dims_t                   dims
);
    import baaq_pkg::*;

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_THR   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int STEP_W = $clog2(DIM_W);

    logic [DIM_W-1:0]   width_reg, height_reg, cols_reg, rows_reg;
    logic [2:0]         state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               ready_reg;

    logic [DIM_W-1:0]   w_quo_reg, w_rem_reg, h_quo_reg, h_rem_reg;
    logic [DIM_W-1:0]   gw_reg, gh_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   full_reg;
    thr_t [NUM_THR-1:0] thr_reg;

    logic [DIM_W-1:0]   width_cl, height_cl, cols_nz, rows_nz;
    logic [DIM_W:0]     w_trial, h_trial, w_diff, h_diff;
    logic               w_fit, h_fit;
    logic [DIM_W-1:0]   gw_c, gh_c;
    logic [35:0]        full_prod;

    // Saturate register values into their working ranges
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    assign width_cl  = clamp_dim(width_reg, DIM_W'(MAX_IMAGE_WIDTH));
    assign height_cl = clamp_dim(height_reg, DIM_W'(MAX_IMAGE_HEIGHT));
    assign cols_nz   = (cols_reg == '0) ? DIM_W'(1) : cols_reg;
    assign rows_nz   = (rows_reg == '0) ? DIM_W'(1) : rows_reg;

    // One restoring divide step per cycle for each dimension
    assign w_trial = {w_rem_reg, w_quo_reg[DIM_W-1]};
    assign h_trial = {h_rem_reg, h_quo_reg[DIM_W-1]};
    assign w_diff  = w_trial - {1'b0, cols_nz};
    assign h_diff  = h_trial - {1'b0, rows_nz};
    assign w_fit   = w_trial >= {1'b0, cols_nz};
    assign h_fit   = h_trial >= {1'b0, rows_nz};

    assign gw_c      = w_quo_reg | DIM_W'(1);
    assign gh_c      = h_quo_reg | DIM_W'(1);
    assign full_prod = count_reg * 10'(FULL_BRIGHTNESS);

    // Register writes and setup sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            cols_reg   <= RST_TEXT_COLUMNS;
            rows_reg   <= RST_TEXT_ROWS;
            state_reg  <= ST_START;
            step_reg   <= '0;
            ready_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_TEXT_COLUMNS: cols_reg   <= cfg_data;
                REG_TEXT_ROWS:    rows_reg   <= cfg_data;
                default:          ;
            endcase
            state_reg <= ST_START;
            ready_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_START:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIM_W - 1))
                        state_reg <= ST_MUL;
                end
                ST_MUL:  state_reg <= ST_FULL;
                ST_FULL: state_reg <= ST_THR;
                ST_THR:
                begin
                    state_reg <= ST_DONE;
                    ready_reg <= 1'b1;
                end
                ST_DONE: state_reg <= ST_DONE;
                default: state_reg <= ST_START;
            endcase
        end
    end

    // Setup datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_START:
            begin
                w_rem_reg <= '0;
                h_rem_reg <= '0;
                w_quo_reg <= width_cl;
                h_quo_reg <= height_cl;
            end
            ST_DIV:
            begin
                w_rem_reg <= w_fit ? w_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
                h_rem_reg <= h_fit ? h_diff[DIM_W-1:0] : h_trial[DIM_W-1:0];
                w_quo_reg <= {w_quo_reg[DIM_W-2:0], w_fit};
                h_quo_reg <= {h_quo_reg[DIM_W-2:0], h_fit};
            end
            ST_MUL:
            begin
                gw_reg    <= gw_c;
                gh_reg    <= gh_c;
                count_reg <= COUNT_W'(gw_c) * COUNT_W'(gh_c);
            end
            ST_FULL: full_reg <= full_prod[SUM_W-1:0];
            ST_THR:
            begin
                for (int i = 0; i < NUM_THR; i++)
                    thr_reg[i] <= THR_W'(full_reg) * THR_W'(tenth(3'(i)));
            end
            default: ;
        endcase
    end

    assign dims.ready  = ready_reg;
    assign dims.width  = width_cl;
    assign dims.height = height_cl;
    assign dims.gw     = gw_reg;
    assign dims.gh     = gh_reg;
    assign dims.thr    = thr_reg;

endmodule

[hw/rtl/baaq_item_q.sv]
// Short queue of classified pixels between the front and back sections.
module baaq_item_q (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  baaq_pkg::item_t   wr_item,
    input  logic              pop,
    output baaq_pkg::item_t   head,
    output baaq_pkg::q_stat_t stat
);
    import baaq_pkg::*;

    item_t               slot_mem [ITEM_Q_DEPTH];
    logic [IQ_PTR_W-1:0] rd_reg, wr_reg;
    logic [IQ_PTR_W:0]   count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            wr_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + IQ_PTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + IQ_PTR_W'(1);
            count_reg <= count_reg + (IQ_PTR_W+1)'(push) - (IQ_PTR_W+1)'(pop);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_reg] <= wr_item;
    end

    assign head           = slot_mem[rd_reg];
    assign stat.has_item  = count_reg != '0;
    assign stat.has_space = count_reg != (IQ_PTR_W+1)'(ITEM_Q_DEPTH);

endmodule

[hw/rtl/baaq_front.sv]
// Front section: takes pixels, tracks raster and group position, classifies each pixel.
module baaq_front (
    input  logic              clk,
    input  logic              rst_n,
    baaq_pix_if.sink          pixels,
    input  baaq_pkg::dims_t   dims,
    input  baaq_pkg::q_stat_t q_stat,
    output logic              q_push,
    output baaq_pkg::item_t   q_item
);
    import baaq_pkg::*;

    logic [DIM_W-1:0]  pc_reg, prow_reg, cig_reg, rig_reg;
    logic [DIM_W-1:0]  gbase_reg, bbase_reg, gw_lat_reg, gh_lat_reg;
    logic [GIDX_W-1:0] gidx_reg;

    logic              accept, fs;
    logic [DIM_W-1:0]  gw, gh;
    logic [DIM_W:0]    band_end, grp_end, cig_inc, rig_inc, pc_inc, prow_inc;
    logic [DIM_W+1:0]  grp_next_end;
    logic              band_act, grp_act, act, col_last, row_last, pc_last, last_grp;
    logic              no_grp, nl_only, emit;

    assign pixels.ready = dims.ready && q_stat.has_space;
    assign accept       = pixels.valid && pixels.ready;

    // Group size is latched at the first pixel of a frame
    assign fs = (pc_reg == '0) && (prow_reg == '0);
    assign gw = fs ? dims.gw : gw_lat_reg;
    assign gh = fs ? dims.gh : gh_lat_reg;

    // Position tests
    assign band_end     = {1'b0, bbase_reg} + {1'b0, gh};
    assign grp_end      = {1'b0, gbase_reg} + {1'b0, gw};
    assign grp_next_end = {1'b0, grp_end} + {2'b0, gw};
    assign cig_inc      = {1'b0, cig_reg} + (DIM_W+1)'(1);
    assign rig_inc      = {1'b0, rig_reg} + (DIM_W+1)'(1);
    assign pc_inc       = {1'b0, pc_reg} + (DIM_W+1)'(1);
    assign prow_inc     = {1'b0, prow_reg} + (DIM_W+1)'(1);

    assign band_act = band_end <= {1'b0, dims.height};
    assign grp_act  = grp_end <= {1'b0, dims.width};
    assign act      = band_act && grp_act;
    assign col_last = cig_inc >= {1'b0, gw};
    assign row_last = rig_inc >= {1'b0, gh};
    assign pc_last  = pc_inc >= {1'b0, dims.width};
    assign last_grp = grp_next_end > {2'b0, dims.width};
    assign no_grp   = gw > dims.width;
    assign nl_only  = !act && band_act && no_grp && row_last && pc_last;
    assign emit     = act && col_last && row_last;

    // Item for the back section
    assign q_item.level     = LEVEL_W'(pixels.red) + LEVEL_W'(pixels.green)
                              + LEVEL_W'(pixels.blue);
    assign q_item.gidx      = gidx_reg;
    assign q_item.acc       = act;
    assign q_item.first_col = cig_reg == '0;
    assign q_item.first_row = rig_reg == '0;
    assign q_item.last_col  = col_last;
    assign q_item.emit      = emit;
    assign q_item.nl        = (emit && last_grp) || nl_only;
    assign q_item.fs        = fs;
    assign q_push           = accept && (act || nl_only || fs);

    // Raster and group counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            prow_reg   <= '0;
            cig_reg    <= '0;
            rig_reg    <= '0;
            gbase_reg  <= '0;
            bbase_reg  <= '0;
            gidx_reg   <= '0;
            gw_lat_reg <= '0;
            gh_lat_reg <= '0;
        end
        else if (accept)
        begin
            gw_lat_reg <= gw;
            gh_lat_reg <= gh;
            if (pc_last)
            begin
                pc_reg    <= '0;
                cig_reg   <= '0;
                gidx_reg  <= '0;
                gbase_reg <= '0;
                if (prow_inc >= {1'b0, dims.height})
                begin
                    prow_reg  <= '0;
                    rig_reg   <= '0;
                    bbase_reg <= '0;
                end
                else
                begin
                    prow_reg <= prow_inc[DIM_W-1:0];
                    if (row_last)
                    begin
                        rig_reg   <= '0;
                        bbase_reg <= band_end[DIM_W-1:0];
                    end
                    else
                        rig_reg <= rig_inc[DIM_W-1:0];
                end
            end
            else
            begin
                pc_reg <= pc_inc[DIM_W-1:0];
                if (act)
                begin
                    if (col_last)
                    begin
                        cig_reg   <= '0;
                        gidx_reg  <= gidx_reg + GIDX_W'(1);
                        gbase_reg <= grp_end[DIM_W-1:0];
                    end
                    else
                        cig_reg <= cig_inc[DIM_W-1:0];
                end
            end
        end
    end

endmodule

[hw/rtl/baaq_back.sv]
// Back section: accumulates group sums in memory, picks characters, buffers results.
module baaq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  baaq_pkg::item_t   q_head,
    input  baaq_pkg::q_stat_t q_stat,
    output logic              q_pop,
    input  baaq_pkg::dims_t   dims,
    baaq_chr_if.source        chars
);
    import baaq_pkg::*;

    // Group sum memory, one entry per group across a row
    logic [SUM_W-1:0]    gsum_mem [MAX_IMAGE_WIDTH];
    logic [SUM_W-1:0]    rdata_reg;

    logic                s1_valid_reg;
    item_t               s1_reg;
    logic                byp_valid_reg;
    logic [SUM_W-1:0]    byp_data_reg, acc_reg;

    logic                s2_valid_reg, s2_emit_reg, s2_nl_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    thr_t [NUM_THR-1:0]  thr_lat_reg;

    oq_entry_t           oq_mem [OUT_Q_DEPTH];
    logic [OQ_PTR_W-1:0] oq_rd_reg, oq_wr_reg;
    logic [OQ_PTR_W:0]   oq_count_reg, oq_after;

    logic                en, oq_pop, wr_en;
    logic [SUM_W-1:0]    base, total;
    logic [SUM10_W-1:0]  sum10;
    logic [2:0]          glyph_sel;
    logic [1:0]          push_cnt;
    oq_entry_t           e_first, e_second;

    // Output buffer handshake; the pipe moves when two slots are free
    assign chars.valid       = oq_count_reg != '0;
    assign chars.char_code   = oq_mem[oq_rd_reg].char_code;
    assign chars.last_of_run = oq_mem[oq_rd_reg].last_of_run;
    assign oq_pop            = chars.valid && chars.ready;
    assign oq_after          = oq_count_reg - (OQ_PTR_W+1)'(oq_pop);
    assign en                = oq_after <= (OQ_PTR_W+1)'(OUT_Q_DEPTH - 2);
    assign q_pop             = en && q_stat.has_item;

    // Stage 1: add pixel level to the running, stored or fresh group sum
    always_comb
    begin
        if (!s1_reg.first_col)
            base = acc_reg;
        else if (s1_reg.first_row)
            base = '0;
        else if (byp_valid_reg)
            base = byp_data_reg;
        else
            base = rdata_reg;
    end

    assign total = base + SUM_W'(s1_reg.level);
    assign wr_en = en && s1_valid_reg && s1_reg.acc && s1_reg.last_col;

    // Memory write of finished row segment, read for the next item
    always_ff @(posedge clk)
    begin
        if (wr_en)
            gsum_mem[s1_reg.gidx] <= total;
        if (en)
            rdata_reg <= gsum_mem[q_head.gidx];
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg       <= q_head;
            byp_data_reg <= total;
            s2_sum_reg   <= total;
            s2_emit_reg  <= s1_reg.emit;
            s2_nl_reg    <= s1_reg.nl;
            if (s1_valid_reg && s1_reg.acc)
                acc_reg <= total;
            if (s1_valid_reg && s1_reg.fs)
                thr_lat_reg <= dims.thr;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg && (s1_reg.emit || s1_reg.nl);
            byp_valid_reg <= wr_en && (s1_reg.gidx == q_head.gidx);
        end
    end

    // Stage 2: brightness ramp lookup, exact integer compare
    assign sum10 = SUM10_W'({s2_sum_reg, 3'b000}) + SUM10_W'({s2_sum_reg, 1'b0});

    always_comb
    begin
        glyph_sel = 3'(NUM_THR);
        for (int i = NUM_THR - 1; i >= 0; i--)
        begin
            if (sum10 < {1'b0, thr_lat_reg[i]})
                glyph_sel = 3'(i);
        end
    end

    assign e_first.char_code    = s2_emit_reg ? glyph_code(glyph_sel) : CHAR_NEWLINE;
    assign e_first.last_of_run  = s2_emit_reg ? !s2_nl_reg : 1'b1;
    assign e_second.char_code   = CHAR_NEWLINE;
    assign e_second.last_of_run = 1'b1;
    assign push_cnt = (en && s2_valid_reg) ? (2'(s2_emit_reg) + 2'(s2_nl_reg)) : 2'd0;

    // Output buffer storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            oq_mem[oq_wr_reg] <= e_first;
        if (push_cnt == 2'd2)
            oq_mem[oq_wr_reg + OQ_PTR_W'(1)] <= e_second;
    end

    // Output buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_rd_reg    <= '0;
            oq_wr_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_reg + OQ_PTR_W'(push_cnt);
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_count_reg <= oq_after + (OQ_PTR_W+1)'(push_cnt);
        end
    end

endmodule

[tb/ascii_frame_checker.sv]
// Predicts the ASCII characters of the quantizer from observed pixel transfers and compares them.
`timescale 1ns / 100ps

module ascii_frame_checker
    import baaq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    baaq_pix_if                  pix,
    baaq_chr_if                  chr,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   chars_pending
);

    localparam int unsigned REG_MAX = (1 << DIM_W) - 1;

    // Character ramp, darkest first, and the brightness steps in tenths between its entries
    localparam byte         GLYPH_RAMP [8]  = '{" ", ":", "*", "o", "&", "*", "@", "#"};
    localparam int unsigned TENTH_STEPS [7] = '{1, 2, 3, 4, 5, 6, 8};

    // Live registers
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    logic [DIM_W-1:0] reg_columns;
    logic [DIM_W-1:0] reg_rows;

    // Raster position and group geometry latched at frame start
    logic [SUM_W-1:0] band_sums [MAX_IMAGE_WIDTH];
    int unsigned      col, row, col_in_grp, row_in_grp, grp, band;
    int unsigned      grp_w, grp_h;

    oq_entry_t        chars_due [$];

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned top);
        if (v == '0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // Exact threshold compare: 10*sum < t*count*765
    function automatic logic [CHAR_W-1:0] brightness_glyph(input longint unsigned sum,
                                                           input longint unsigned count);
        longint unsigned full;
        full = count * FULL_BRIGHTNESS;
        for (int i = 0; i < 7; i++)
            if (10 * sum < TENTH_STEPS[i] * full)
                return CHAR_W'(GLYPH_RAMP[i]);
        return CHAR_W'(GLYPH_RAMP[7]);
    endfunction

    // Fold one pixel into the group sums and queue the characters it completes
    task automatic quantize_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                  input logic [PIX_W-1:0] b);
        int unsigned       wl, hl, ngx, nby;
        longint unsigned   cells;
        logic [SUM_W-1:0]  v;
        logic [CHAR_W-1:0] codes [2];
        int                n;

        n  = 0;
        wl = clamp_dim(reg_width, MAX_IMAGE_WIDTH);
        hl = clamp_dim(reg_height, MAX_IMAGE_HEIGHT);
        if (col == 0 && row == 0)
        begin
            grp_w = (wl / clamp_dim(reg_columns, REG_MAX)) | 1;
            grp_h = (hl / clamp_dim(reg_rows, REG_MAX)) | 1;
        end
        ngx = wl / grp_w;
        nby = hl / grp_h;
        if (ngx > MAX_IMAGE_WIDTH)
            ngx = MAX_IMAGE_WIDTH;
        v = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);

        if (band < nby && grp < ngx)
        begin
            if (row_in_grp == 0 && col_in_grp == 0)
                band_sums[grp] = v;
            else
                band_sums[grp] = band_sums[grp] + v;
            if (col_in_grp + 1 >= grp_w)
            begin
                if (row_in_grp + 1 >= grp_h)
                begin
                    cells    = grp_w;
                    cells    = cells * grp_h;
                    codes[n] = brightness_glyph(band_sums[grp], cells);
                    n++;
                    if (grp + 1 == ngx)
                    begin
                        codes[n] = CHAR_NEWLINE;
                        n++;
                    end
                end
                col_in_grp = 0;
                grp++;
            end
            else
            begin
                col_in_grp++;
            end
        end
        else if (band < nby && ngx == 0 && row_in_grp + 1 >= grp_h && col + 1 >= wl)
        begin
            // no group fits the row: the band still closes with a newline
            codes[0] = CHAR_NEWLINE;
            n        = 1;
        end

        for (int i = 0; i < n; i++)
            chars_due.push_back(oq_entry_t'{char_code: codes[i], last_of_run: (i == n - 1)});

        // Row and frame ends follow the live geometry
        col++;
        if (col >= wl)
        begin
            col        = 0;
            col_in_grp = 0;
            grp        = 0;
            row++;
            row_in_grp++;
            if (row_in_grp >= grp_h)
            begin
                row_in_grp = 0;
                band++;
            end
            if (row >= hl)
            begin
                row        = 0;
                row_in_grp = 0;
                band       = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        oq_entry_t want;
        if (!rst_n)
        begin
            reg_width      = RST_IMAGE_WIDTH;
            reg_height     = RST_IMAGE_HEIGHT;
            reg_columns    = RST_TEXT_COLUMNS;
            reg_rows       = RST_TEXT_ROWS;
            col            = 0;
            row            = 0;
            col_in_grp     = 0;
            row_in_grp     = 0;
            grp            = 0;
            band           = 0;
            grp_w          = 1;
            grp_h          = 1;
            chars_due.delete();
            mismatch_count <= 0;
            chars_pending  <= 0;
        end
        else
        begin
            // Register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  reg_width   = cfg_data;
                    REG_IMAGE_HEIGHT: reg_height  = cfg_data;
                    REG_TEXT_COLUMNS: reg_columns = cfg_data;
                    REG_TEXT_ROWS:    reg_rows    = cfg_data;
                    default:          ;
                endcase
            end

            // Pixel transfer
            if (pix.valid && pix.ready)
                quantize_pixel(pix.red, pix.green, pix.blue);

            // Character transfer
            if (chr.valid && chr.ready)
            begin
                if (chars_due.size() == 0)
                begin
                    $error("char_code %0d arrived with no character pending", chr.char_code);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (chr.char_code !== want.char_code)
                    begin
                        $error("char_code: expected %0d, got %0d", want.char_code,
                               chr.char_code);
                        mismatch_count <= mismatch_count + 1;
                    end
                    else if (chr.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                               chr.last_of_run);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            chars_pending <= chars_due.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the block-average ASCII quantizer.
`timescale 1ns / 100ps

module tb_top;
    import baaq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int ITEMS_PER_PACE = 110;
    localparam int WIDE_PIXELS    = 48;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    int                   mismatch_count;
    int                   chars_pending;
    pace_e                pace;
    bit                   hold_trigger;

    baaq_pix_if pix ();
    baaq_chr_if chr ();

    block_average_ascii_quantizer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix),
        .chars     (chr),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ascii_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix            (pix),
        .chr            (chr),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic int send_gap_pct(input pace_e p);
        case (p)
            PACE_SENDER_IDLE: return 86;
            PACE_BOTH:        return 33;
            default:          return 0;
        endcase
    endfunction

    function automatic int stall_pct(input pace_e p);
        case (p)
            PACE_RECEIVER_STALL: return 86;
            PACE_BOTH:           return 33;
            default:             return 0;
        endcase
    endfunction

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned top);
        if (v == '0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // Character receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_ack;
        hold_ack = 1'b0;
        chr.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger != hold_ack)
            begin
                hold_ack = hold_trigger;
                chr.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            chr.ready <= ($urandom_range(99) >= stall_pct(pace));
        end
    end

    // One pixel transfer, with optional idle cycles ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        while ($urandom_range(99) < send_gap_pct(pace))
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
    endtask

    // Pixel whose channels add up to a given brightness sum
    task automatic send_sum(input int s);
        int r, g;
        r = (s > 255) ? 255 : s;
        g = (s - r > 255) ? 255 : s - r;
        send_pixel(PIX_W'(r), PIX_W'(g), PIX_W'(s - r - g));
    endtask

    task automatic send_random_pixel();
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    endtask

    // Wait until every predicted character has left, then let the pipeline settle
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] tc, input logic [DIM_W-1:0] tr);
        logic [DIM_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{w, h, tc, tr};
        idx  = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TEXT_COLUMNS, REG_TEXT_ROWS};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] shaped_channel(input int style, input int base);
        int t;
        case (style)
            0:       t = $urandom_range(255);
            1:       t = base + int'($urandom_range(40)) - 20;
            default: t = $urandom_range(1) ? 255 : 0;
        endcase
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return PIX_W'(t);
    endfunction

    // One whole frame at a random small geometry; returns the pixels sent
    task automatic random_frame(output int sent);
        logic [DIM_W-1:0] w, h, tc, tr;
        int unsigned      wl, hl;
        int               style, base;

        w  = ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(1, 20));
        h  = ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(1, 10));
        wl = clamp_dim(w, MAX_IMAGE_WIDTH);
        hl = clamp_dim(h, MAX_IMAGE_HEIGHT);
        case ($urandom_range(7))
            0:       tc = '0;
            1:       tc = '1;
            default: tc = DIM_W'($urandom_range(1, wl + 1));
        endcase
        case ($urandom_range(7))
            0:       tr = '0;
            1:       tr = '1;
            default: tr = DIM_W'($urandom_range(1, hl + 1));
        endcase
        configure(w, h, tc, tr);

        style = $urandom_range(2);
        base  = $urandom_range(255);
        sent  = wl * hl;
        for (int i = 0; i < sent; i++)
            send_pixel(shaped_channel(style, base), shaped_channel(style, base),
                       shaped_channel(style, base));
        drain();
    endtask

    // Stimulus
    initial
    begin
        int sums [16];
        int sent, pace_items;

        sums = '{0, 76, 77, 152, 153, 229, 230, 305, 306, 382, 383, 458, 459, 611, 612, 765};
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= '0;
        pix.valid    <= 1'b0;
        pix.red      <= '0;
        pix.green    <= '0;
        pix.blue     <= '0;
        pace         <= PACE_STEADY;
        hold_trigger <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-pixel groups around every threshold; height and rows saturate
        configure('d1, '1, 'd1, '1);
        foreach (sums[i])
            send_sum(sums[i]);
        drain();
        // Height cut mid-frame below the current row: frame ends at the next row end
        configure('d1, 'd5, 'd1, '1);
        send_sum(765);
        drain();

        // Group wider than the image: one newline per band
        configure('d2, 'd2, 'd1, 'd2);
        repeat (4) send_random_pixel();
        drain();

        // Zero width and zero columns act as one
        configure('0, 'd3, '0, 'd1);
        send_pixel('1, '1, '1);
        send_pixel('0, '0, '0);
        send_pixel('1, '0, '1);
        drain();

        // Widest row: width saturates so groups are one pixel wide, not three;
        // zero height and rows act as one. A narrower width then cuts the row short.
        configure('1, '0, 'd3000, '0);
        repeat (WIDE_PIXELS) send_random_pixel();
        drain();
        configure(DIM_W'(WIDE_PIXELS + 1), '0, 'd3000, '0);
        send_random_pixel();
        drain();

        // Long receiver hold-off while pixels keep coming
        configure('d16, 'd4, 'd16, 'd4);
        hold_trigger <= 1'b1;
        repeat (64) send_random_pixel();
        drain();

        // Random frames under each pacing
        for (int p = 0; p < 4; p++)
        begin
            pace       <= pace_e'(p);
            pace_items = 0;
            while (pace_items < ITEMS_PER_PACE)
            begin
                random_frame(sent);
                pace_items += sent;
            end
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
